[design/ts_pid_filter_table_core_macros.svh]
// Assertion macros used by the PID filter table checker.
`ifndef TS_PID_FILTER_TABLE_CORE_MACROS_SVH
`define TS_PID_FILTER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPFT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSPFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tspft_pkg.sv]
// Package: codes, sizes and the request token of the PID filter table.
package tspft_pkg;

    // Default sizes
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int SUBSCRIBERS_DEF   = 8;

    // Fixed field widths
    localparam int PID_W   = 13;
    localparam int SUB_W   = 3;
    localparam int OMASK_W = 8;
    localparam int TEI_POS = 7;

    // Request types
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_SUB    = 2'd1;
    localparam logic [1:0] REQ_UNSUB  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
    localparam logic [1:0] ST_DUP         = 2'd3;

    // Output stream layout
    localparam int MT_PID_LSB  = 0;
    localparam int MT_MASK_LSB = PID_W;
    localparam int MT_W        = 24;
    localparam int MU_TERR     = 2;
    localparam int MU_FWD      = 3;
    localparam int MU_W        = 4;

    // Control part of the request token walking down the cell row
    typedef struct packed {
        logic       vld;
        logic [1:0] op;
        logic       done;
        logic       shift;
        logic       fwd;
        logic [1:0] status;
    } tspft_tok_t;

endpackage

[design/ts_pid_filter_table_core.sv]
// Lookups and table updates: the request token walks the cell row from the head token
// register through every cell, then the result holding stage and the output register;
// dropped packets and rejected requests skip the row and go to the result holding stage.
// One request at a time: the next is taken once the previous result sits in the output register.
// Reset: synchronous, active low; clears all entry valid bits at once, no clearing pass.
// Top level: PID filter table built as a row of entry cells.
module ts_pid_filter_table_core
    import tspft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SUBSCRIBERS   = SUBSCRIBERS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,  // header_byte1, header_byte2, pid, subscriber
    input  logic [1:0]       s_tuser,  // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [MT_W-1:0]  m_tdata,  // matched_pid, subscriber_mask, zero pad
    output logic [MU_W-1:0]  m_tuser   // status, transport_error, forward
);

    localparam int N = TABLE_ENTRIES;

    // input fields
    logic [1:0]       in_req;
    logic [7:0]       in_b1, in_b2;
    logic [PID_W-1:0] in_pid, in_hpid;
    logic [SUB_W-1:0] in_sub;
    logic             accept, sub_bad;

    assign in_req  = s_tuser;
    assign in_b1   = s_tdata[7:0];
    assign in_b2   = s_tdata[15:8];
    assign in_pid  = s_tdata[28:16];
    assign in_sub  = s_tdata[31:29];
    assign in_hpid = {in_b1[4:0], in_b2};
    assign accept  = s_tvalid && s_tready;
    assign sub_bad = 32'(in_sub) >= 32'(SUBSCRIBERS);

    // cell row wiring
    tspft_tok_t             tok   [0:N];
    logic [PID_W-1:0]       tpid  [0:N];
    logic [SUBSCRIBERS-1:0] tbit  [0:N];
    logic [SUBSCRIBERS-1:0] tmask [0:N];
    logic                   ev    [0:N-1];
    logic [PID_W-1:0]       ep    [0:N-1];
    logic [SUBSCRIBERS-1:0] em    [0:N-1];

    // head token register
    tspft_tok_t             head_tok_reg, head_tok_next;
    logic [PID_W-1:0]       head_pid_reg;
    logic [SUBSCRIBERS-1:0] head_bit_reg;

    // result holding stage and output register
    logic                   busy_reg, busy_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             rst_reg, rst_next;
    logic                   rterr_reg, rterr_next;
    logic                   rfwd_reg, rfwd_next;
    logic [PID_W-1:0]       rpid_reg, rpid_next;
    logic [OMASK_W-1:0]     rmask_reg, rmask_next;
    logic                   mvalid_reg, mvalid_next;
    logic [MT_W-1:0]        mdata_reg;
    logic [MU_W-1:0]        muser_reg;
    logic                   move;
    logic                   imm;
    logic [SUBSCRIBERS+OMASK_W-1:0] tail_mask_ext;

    assign tok[0]   = head_tok_reg;
    assign tpid[0]  = head_pid_reg;
    assign tbit[0]  = head_bit_reg;
    assign tmask[0] = '0;

    generate
        for (genvar i = 0; i < N; i++) begin : g_cell
            logic                   nv;
            logic [PID_W-1:0]       np;
            logic [SUBSCRIBERS-1:0] nm;
            if (i < N - 1) begin : g_nbr
                assign nv = ev[i+1];
                assign np = ep[i+1];
                assign nm = em[i+1];
            end else begin : g_end
                assign nv = 1'b0;
                assign np = '0;
                assign nm = '0;
            end
            tspft_cell #(.SUBSCRIBERS(SUBSCRIBERS)) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .tok_i       (tok[i]),
                .tok_pid_i   (tpid[i]),
                .tok_bit_i   (tbit[i]),
                .tok_mask_i  (tmask[i]),
                .nbr_valid_i (nv),
                .nbr_pid_i   (np),
                .nbr_mask_i  (nm),
                .ent_valid_o (ev[i]),
                .ent_pid_o   (ep[i]),
                .ent_mask_o  (em[i]),
                .tok_o       (tok[i+1]),
                .tok_pid_o   (tpid[i+1]),
                .tok_bit_o   (tbit[i+1]),
                .tok_mask_o  (tmask[i+1])
            );
        end
    endgenerate

    assign tail_mask_ext = {{OMASK_W{1'b0}}, tmask[N]};

    // requests that need no table walk
    assign imm = (in_req == REQ_NONE) || ((in_req == REQ_PACKET) && in_b1[TEI_POS])
                 || (((in_req == REQ_SUB) || (in_req == REQ_UNSUB)) && sub_bad);

    assign move = pend_reg && (!mvalid_reg || m_tready);

    // request launch and result collection
    always_comb begin
        head_tok_next = '0;
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        rst_next      = rst_reg;
        rterr_next    = rterr_reg;
        rfwd_next     = rfwd_reg;
        rpid_next     = rpid_reg;
        rmask_next    = rmask_reg;
        mvalid_next   = mvalid_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        if (move) begin
            mvalid_next = 1'b1;
            pend_next   = 1'b0;
            busy_next   = 1'b0;
        end

        if (accept) begin
            busy_next = 1'b1;
            if (imm) begin
                pend_next  = 1'b1;
                rterr_next = 1'b0;
                rfwd_next  = 1'b0;
                rmask_next = '0;
                rst_next   = ST_OK;
                rpid_next  = '0;
                if (in_req == REQ_PACKET) begin
                    rterr_next = 1'b1;
                    rpid_next  = in_hpid;
                end else if (in_req != REQ_NONE) begin
                    rst_next  = ST_NOT_PRESENT;
                    rpid_next = in_pid;
                end
            end else begin
                head_tok_next.vld = 1'b1;
                head_tok_next.op  = in_req;
            end
        end

        // token leaving the last cell
        if (tok[N].vld) begin
            pend_next  = 1'b1;
            rterr_next = 1'b0;
            rfwd_next  = tok[N].fwd;
            rpid_next  = tpid[N];
            rmask_next = tail_mask_ext[OMASK_W-1:0];
            rst_next   = tok[N].status;
            if (!tok[N].done) begin
                if (tok[N].op == REQ_SUB) begin
                    rst_next = ST_FULL;
                end else if (tok[N].op == REQ_UNSUB) begin
                    rst_next = ST_NOT_PRESENT;
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_tok_reg <= '0;
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            mvalid_reg   <= 1'b0;
        end else begin
            head_tok_reg <= head_tok_next;
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rst_reg   <= rst_next;
        rterr_reg <= rterr_next;
        rfwd_reg  <= rfwd_next;
        rpid_reg  <= rpid_next;
        rmask_reg <= rmask_next;
        if (accept) begin
            head_pid_reg <= (in_req == REQ_PACKET) ? in_hpid : in_pid;
            head_bit_reg <= SUBSCRIBERS'(1) << in_sub;
        end
        if (move) begin
            mdata_reg <= {{(MT_W - PID_W - OMASK_W){1'b0}}, rmask_reg, rpid_reg};
            muser_reg <= {rfwd_reg, rterr_reg, rst_reg};
        end
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

[design/tspft_cell.sv]
// One table entry cell: holds an entry and processes the request token passing by.
module tspft_cell
    import tspft_pkg::*;
#(
    parameter int SUBSCRIBERS = SUBSCRIBERS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // token from the previous cell
    input  tspft_tok_t             tok_i,
    input  logic [PID_W-1:0]       tok_pid_i,
    input  logic [SUBSCRIBERS-1:0] tok_bit_i,
    input  logic [SUBSCRIBERS-1:0] tok_mask_i,
    // entry of the next cell, used when compacting
    input  logic                   nbr_valid_i,
    input  logic [PID_W-1:0]       nbr_pid_i,
    input  logic [SUBSCRIBERS-1:0] nbr_mask_i,
    // own entry, seen by the previous cell
    output logic                   ent_valid_o,
    output logic [PID_W-1:0]       ent_pid_o,
    output logic [SUBSCRIBERS-1:0] ent_mask_o,
    // token to the next cell
    output tspft_tok_t             tok_o,
    output logic [PID_W-1:0]       tok_pid_o,
    output logic [SUBSCRIBERS-1:0] tok_bit_o,
    output logic [SUBSCRIBERS-1:0] tok_mask_o
);

    logic                   valid_reg, valid_next;
    logic [PID_W-1:0]       pid_reg, pid_next;
    logic [SUBSCRIBERS-1:0] mask_reg, mask_next;
    tspft_tok_t             tok_reg, tok_next;
    logic [PID_W-1:0]       tpid_reg;
    logic [SUBSCRIBERS-1:0] tbit_reg;
    logic [SUBSCRIBERS-1:0] tmask_reg, tmask_next;
    logic                   hit;
    logic                   has_bit;
    logic [SUBSCRIBERS-1:0] cleared;

    assign hit     = valid_reg && (pid_reg == tok_pid_i);
    assign has_bit = |(mask_reg & tok_bit_i);
    assign cleared = mask_reg & ~tok_bit_i;

    // entry update and token handling
    always_comb begin
        valid_next = valid_reg;
        pid_next   = pid_reg;
        mask_next  = mask_reg;
        tok_next   = tok_i;
        tmask_next = tok_mask_i;
        if (tok_i.vld) begin
            if (tok_i.shift) begin
                // an earlier entry was freed: pull the next one down
                valid_next = nbr_valid_i;
                pid_next   = nbr_pid_i;
                mask_next  = nbr_mask_i;
            end else if (!tok_i.done) begin
                if (hit) begin
                    tok_next.done = 1'b1;
                    unique case (tok_i.op)
                        REQ_PACKET: begin
                            tmask_next   = mask_reg;
                            tok_next.fwd = |mask_reg;
                        end
                        REQ_SUB: begin
                            if (has_bit) begin
                                tok_next.status = ST_DUP;
                                tmask_next      = mask_reg;
                            end else begin
                                mask_next  = mask_reg | tok_bit_i;
                                tmask_next = mask_reg | tok_bit_i;
                            end
                        end
                        REQ_UNSUB: begin
                            if (!has_bit) begin
                                tok_next.status = ST_NOT_PRESENT;
                                tmask_next      = mask_reg;
                            end else begin
                                tmask_next = cleared;
                                mask_next  = cleared;
                                if (cleared == '0) begin
                                    // entry freed: close the gap
                                    tok_next.shift = 1'b1;
                                    valid_next     = nbr_valid_i;
                                    pid_next       = nbr_pid_i;
                                    mask_next      = nbr_mask_i;
                                end
                            end
                        end
                        default: ;
                    endcase
                end else if (!valid_reg) begin
                    // first free cell: valid entries stay packed below it
                    tok_next.done = 1'b1;
                    if (tok_i.op == REQ_SUB) begin
                        valid_next = 1'b1;
                        pid_next   = tok_pid_i;
                        mask_next  = tok_bit_i;
                        tmask_next = tok_bit_i;
                    end else if (tok_i.op == REQ_UNSUB) begin
                        tok_next.status = ST_NOT_PRESENT;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pid_reg   <= pid_next;
        mask_reg  <= mask_next;
        tpid_reg  <= tok_pid_i;
        tbit_reg  <= tok_bit_i;
        tmask_reg <= tmask_next;
    end

    assign ent_valid_o = valid_reg;
    assign ent_pid_o   = pid_reg;
    assign ent_mask_o  = mask_reg;
    assign tok_o       = tok_reg;
    assign tok_pid_o   = tpid_reg;
    assign tok_bit_o   = tbit_reg;
    assign tok_mask_o  = tmask_reg;

endmodule

[design/tspft_checker.sv]
// Port-level checker for the PID filter table, bound to the top level.
`include "ts_pid_filter_table_core_macros.svh"

module tspft_checker
    import tspft_pkg::*;
(
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [MT_W-1:0] m_tdata,
    input logic [MU_W-1:0] m_tuser
);

    logic [1:0]         st;
    logic [OMASK_W-1:0] msk;

    assign st  = m_tuser[1:0];
    assign msk = m_tdata[MT_MASK_LSB +: OMASK_W];

    // a stalled result holds
    `TSPFT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one request at a time
    `TSPFT_ASSERT_NEXT(a_one, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // dropped packet carries no mask and no status
    `TSPFT_ASSERT_NOW(a_drop, aclk, aresetn, m_tvalid && m_tuser[MU_TERR], st == ST_OK && !m_tuser[MU_FWD] && msk == '0, "dropped packet result wrong")

    // forwarded packet has subscribers
    `TSPFT_ASSERT_NOW(a_fwd, aclk, aresetn, m_tvalid && m_tuser[MU_FWD], st == ST_OK && msk != '0, "forward without subscribers")

    // full table gives an empty mask
    `TSPFT_ASSERT_NOW(a_full, aclk, aresetn, m_tvalid && st == ST_FULL, msk == '0 && !m_tuser[MU_TERR], "full result carries mask")

endmodule

bind ts_pid_filter_table_core tspft_checker u_tspft_checker (.*);

[bench/tb_top.sv]
// Testbench for the PID filter table: directed table, then random requests checked against a local table model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tspft_pkg::*;

    localparam int NUM_SLOTS    = TABLE_ENTRIES_DEF;
    localparam int LATENCY      = NUM_SLOTS + 2;
    localparam int RANDOM_ITEMS = 950;
    localparam int POOL_SIZE    = 48;
    localparam int LONG_STALL   = 400;
    localparam int STALL_AT     = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_DIRECTED = 22;

    // One request as seen on the input stream
    typedef struct packed {
        logic [1:0]       req;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [PID_W-1:0] pid;
        logic [SUB_W-1:0] sub;
    } pid_req_t;

    // One result as seen on the output stream
    typedef struct packed {
        logic [1:0]         status;
        logic               terr;
        logic               fwd;
        logic [PID_W-1:0]   mpid;
        logic [OMASK_W-1:0] mask;
    } pid_res_t;

    typedef struct packed {
        pid_req_t req;
        logic     typed;
        pid_res_t want;
    } dir_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;  // header_byte1, header_byte2, pid, subscriber
    logic [1:0]        s_tuser  = '0;  // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [MT_W-1:0]   m_tdata;        // matched_pid, subscriber_mask, zero pad
    logic [MU_W-1:0]   m_tuser;        // status, transport_error, forward

    // Local copy of the filter table
    logic               tbl_valid [NUM_SLOTS];
    logic [PID_W-1:0]   tbl_pid   [NUM_SLOTS];
    logic [OMASK_W-1:0] tbl_mask  [NUM_SLOTS];

    pid_res_t pending_results[$];
    int       error_count  = 0;
    int       sent_count   = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;

    ts_pid_filter_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    initial begin : table_init
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mask[i]  = '0;
        end
    end

    function automatic int find_entry(logic [PID_W-1:0] p);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_valid[i] && tbl_pid[i] == p) return i;
        end
        return -1;
    endfunction

    // Table model: returns the result of one request and updates the table
    function automatic pid_res_t filter_step(pid_req_t r);
        pid_res_t           res;
        int                 slot;
        int                 free_slot;
        logic [OMASK_W-1:0] bit_sel;
        res = '0;
        case (r.req)
            REQ_PACKET: begin
                res.mpid = {r.b1[4:0], r.b2};
                if (r.b1[TEI_POS]) begin
                    res.terr = 1'b1;
                end else begin
                    slot = find_entry(res.mpid);
                    if (slot >= 0) begin
                        res.mask = tbl_mask[slot];
                        res.fwd  = |tbl_mask[slot];
                    end
                end
            end
            REQ_SUB, REQ_UNSUB: begin
                res.mpid = r.pid;
                if (int'(r.sub) >= SUBSCRIBERS_DEF) begin
                    res.status = ST_NOT_PRESENT;
                end else begin
                    bit_sel = OMASK_W'(1) << r.sub;
                    slot    = find_entry(r.pid);
                    if (r.req == REQ_SUB) begin
                        if (slot < 0) begin
                            // new entry goes to the lowest free slot
                            free_slot = -1;
                            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                                if (!tbl_valid[i]) free_slot = i;
                            end
                            if (free_slot < 0) begin
                                res.status = ST_FULL;
                            end else begin
                                tbl_valid[free_slot] = 1'b1;
                                tbl_pid[free_slot]   = r.pid;
                                tbl_mask[free_slot]  = bit_sel;
                                res.mask             = bit_sel;
                            end
                        end else if ((tbl_mask[slot] & bit_sel) != 0) begin
                            res.status = ST_DUP;
                            res.mask   = tbl_mask[slot];
                        end else begin
                            tbl_mask[slot] = tbl_mask[slot] | bit_sel;
                            res.mask       = tbl_mask[slot];
                        end
                    end else begin
                        if (slot < 0) begin
                            res.status = ST_NOT_PRESENT;
                        end else if ((tbl_mask[slot] & bit_sel) == 0) begin
                            res.status = ST_NOT_PRESENT;
                            res.mask   = tbl_mask[slot];
                        end else begin
                            tbl_mask[slot] = tbl_mask[slot] & ~bit_sel;
                            res.mask       = tbl_mask[slot];
                            if (tbl_mask[slot] == 0) tbl_valid[slot] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_error(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one request, queue its expected result, then idle for a random gap except in back-to-back runs
    task automatic send_req(pid_req_t r, logic typed, pid_res_t want);
        pid_res_t predicted;
        int       gap;
        s_tuser  <= r.req;
        s_tdata  <= {r.sub, r.pid, r.b2, r.b1};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = filter_step(r);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
        gap = (sent_count % 200 < 30) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering until every result is back and the block has settled
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Stimulus
    initial begin : stimulus
        dir_row_t         directed_rows [NUM_DIRECTED];
        logic [PID_W-1:0] pool [POOL_SIZE];
        int               held[$];
        pid_req_t         r;
        int               counted;
        int               pick;
        int               slot;
        int               start;
        logic             fill_mode;
        logic             paused;

        directed_rows = '{
            // empty table, PID zero
            '{'{REQ_PACKET, 8'h00, 8'h00, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'd0, 8'h00}},
            // error bit set, all bits high
            '{'{REQ_PACKET, 8'hFF, 8'hFF, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_OK, 1'b1, 1'b0, 13'h1FFF, 8'h00}},
            // top PID, unused header bits set, no entry
            '{'{REQ_PACKET, 8'h7F, 8'hFF, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h00}},
            '{'{REQ_UNSUB, 8'h00, 8'h00, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_NOT_PRESENT, 1'b0, 1'b0, 13'h1FFF, 8'h00}},
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h80}},
            // duplicate subscribe
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_DUP, 1'b0, 1'b0, 13'h1FFF, 8'h80}},
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h1FFF, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h81}},
            '{'{REQ_PACKET, 8'h1F, 8'hFF, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b1, 13'h1FFF, 8'h81}},
            // dropped even though the PID matches
            '{'{REQ_PACKET, 8'hFF, 8'hFF, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b1, 1'b0, 13'h1FFF, 8'h00}},
            '{'{REQ_PACKET, 8'h7F, 8'hFF, 13'h0AAA, 3'd5}, 1'b0, '0},
            // subscriber not in an existing entry
            '{'{REQ_UNSUB, 8'h00, 8'h00, 13'h1FFF, 3'd3}, 1'b1,
              '{ST_NOT_PRESENT, 1'b0, 1'b0, 13'h1FFF, 8'h81}},
            '{'{REQ_UNSUB, 8'h00, 8'h00, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h01}},
            // last subscriber leaves, entry freed
            '{'{REQ_UNSUB, 8'h00, 8'h00, 13'h1FFF, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h00}},
            '{'{REQ_PACKET, 8'h1F, 8'hFF, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'h1FFF, 8'h00}},
            // unused request type
            '{'{REQ_NONE, 8'hFF, 8'hFF, 13'h1FFF, 3'd7}, 1'b1, '0},
            '{'{REQ_SUB, 8'hFF, 8'hFF, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'd0, 8'h01}},
            '{'{REQ_PACKET, 8'h00, 8'h00, 13'h1FFF, 3'd7}, 1'b1,
              '{ST_OK, 1'b0, 1'b1, 13'd0, 8'h01}},
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h0AAA, 3'd3}, 1'b0, '0},
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h1555, 3'd4}, 1'b0, '0},
            '{'{REQ_PACKET, 8'h0A, 8'hAA, 13'h1555, 3'd2}, 1'b0, '0},
            '{'{REQ_UNSUB, 8'h00, 8'h00, 13'd0, 3'd0}, 1'b1,
              '{ST_OK, 1'b0, 1'b0, 13'd0, 8'h00}},
            '{'{REQ_SUB, 8'h00, 8'h00, 13'h0AAA, 3'd5}, 1'b0, '0}
        };

        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) pool[i] = PID_W'($urandom_range(0, 8191));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        hold_until_drained();

        // Random part: alternating fill and drain phases over a small PID pool
        counted = 0;
        paused  = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (!paused && counted == RANDOM_ITEMS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            fill_mode = ((counted / 150) % 2 == 0);
            r.req = REQ_PACKET;
            r.b1  = 8'($urandom);
            r.b2  = 8'($urandom);
            r.pid = PID_W'($urandom);
            r.sub = SUB_W'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 4) begin
                r.req = REQ_NONE;
            end else if (pick < 10) begin
                // noise: random request of a real type
                r.req = 2'($urandom_range(0, 2));
                counted++;
            end else if (pick < 40) begin
                // header of a packet, mostly on a pooled PID
                if ($urandom_range(0, 4) != 0) begin
                    r.pid = pool[$urandom_range(0, POOL_SIZE - 1)];
                    r.b1  = {($urandom_range(0, 9) == 0), 2'($urandom), r.pid[12:8]};
                    r.b2  = r.pid[7:0];
                end
                counted++;
            end else if (pick < (fill_mode ? 85 : 52)) begin
                r.req = REQ_SUB;
                r.pid = pool[$urandom_range(0, POOL_SIZE - 1)];
                counted++;
            end else begin
                // unsubscribe, mostly a pair the table holds
                r.req = REQ_UNSUB;
                held.delete();
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_valid[i]) held.push_back(i);
                end
                if (held.size() > 0 && $urandom_range(0, 3) != 0) begin
                    slot  = held[$urandom_range(0, held.size() - 1)];
                    start = $urandom_range(0, 7);
                    r.pid = tbl_pid[slot];
                    for (int k = 0; k < 8; k++) begin
                        if (tbl_mask[slot][(start + k) % 8]) r.sub = SUB_W'((start + k) % 8);
                    end
                end else begin
                    r.pid = pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                counted++;
            end
            send_req(r, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (error_count == 0) begin
            $display("ts_pid_filter_table_core regression: pass");
        end else begin
            $display("ts_pid_filter_table_core regression: fail");
        end
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, field checks
    initial begin : result_sink
        int       hold;
        pid_res_t want;
        pid_res_t got;
        forever begin
            hold = (results_seen % 250 < 40) ? 0 : $urandom_range(0, 16);
            if (results_seen == STALL_AT) hold = LONG_STALL;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            got.status = m_tuser[1:0];
            got.terr   = m_tuser[MU_TERR];
            got.fwd    = m_tuser[MU_FWD];
            got.mpid   = m_tdata[MT_PID_LSB +: PID_W];
            got.mask   = m_tdata[MT_MASK_LSB +: OMASK_W];
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result with nothing pending: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    flag_error($sformatf("result %0d status %0d, want %0d",
                                         results_seen, got.status, want.status));
                if (got.terr !== want.terr)
                    flag_error($sformatf("result %0d transport_error %0d, want %0d",
                                         results_seen, got.terr, want.terr));
                if (got.fwd !== want.fwd)
                    flag_error($sformatf("result %0d forward %0d, want %0d",
                                         results_seen, got.fwd, want.fwd));
                if (got.mpid !== want.mpid)
                    flag_error($sformatf("result %0d matched_pid %h, want %h",
                                         results_seen, got.mpid, want.mpid));
                if (got.mask !== want.mask)
                    flag_error($sformatf("result %0d subscriber_mask %h, want %h",
                                         results_seen, got.mask, want.mask));
            end
            results_seen++;
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ts_pid_filter_table_core regression: fail");
        $finish;
    end

endmodule
